@@ rtl/njtb_pkg.sv @@
// Shared constants and helpers for the neighbor-joining tree builder.
// No dependencies; imported by njtb_div and the tree builder unit.
package njtb_pkg;

	// Row sum width and working width of Q values, numerators and quotients
	localparam int SUM_W = 48;
	localparam int NUM_W = 50;

	// First internal node id of every run
	localparam logic [10:0] FIRST_INTERNAL = 11'd1000;

	// Configuration register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_TAXA_COUNT     = 2'd0;
	localparam logic [1:0] REG_OUTGROUP_FIRST = 2'd1;
	localparam logic [1:0] REG_PREV_GEN_COUNT = 2'd2;

	// Saturate a working-width value to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [NUM_W-1:0] v);
		logic signed [NUM_W-1:0] hi;
		logic signed [NUM_W-1:0] lo;
		hi = {{(NUM_W-32){1'b0}}, 32'h7fffffff};
		lo = {{(NUM_W-32){1'b1}}, 32'h80000000};
		if (v > hi) begin
			return 32'sh7fffffff;
		end else if (v < lo) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

@@ rtl/njtb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module njtb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/njtb_div.sv @@
// Radix-2 restoring divider giving the floor quotient of a signed numerator
// by a positive divisor, one quotient bit per cycle. Depends on njtb_pkg.
module njtb_div #(
	parameter int DEN_W = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [njtb_pkg::NUM_W-1:0] num,
	input  logic [DEN_W-1:0]                  den,
	output logic                              done,
	output logic signed [njtb_pkg::NUM_W-1:0] quo
);
	import njtb_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               neg_q;
	logic [NUM_W-1:0]   mag_q;
	logic [DEN_W-1:0]   rem_q;
	logic [DEN_W-1:0]   den_q;
	logic signed [NUM_W-1:0] quo_q;

	logic [DEN_W:0]     rem_sh;
	logic               fits;
	logic [DEN_W:0]     rem_sub;
	logic [DEN_W-1:0]   rem_nx;

	// one restoring step
	always_comb begin
		rem_sh  = {rem_q, mag_q[NUM_W-1]};
		fits    = rem_sh >= {1'b0, den_q};
		rem_sub = rem_sh - {1'b0, den_q};
		rem_nx  = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: magnitude shifts out, quotient bits shift in; sign fixup at end
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NUM_W-1];
			mag_q <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				mag_q <= {mag_q[NUM_W-2:0], fits};
				rem_q <= rem_nx;
			end else begin
				quo_q <= neg_q ? (-$signed(mag_q) - NUM_W'(rem_q != '0)) : $signed(mag_q);
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

@@ rtl/neighbor_joining_tree_builder_unit.sv @@
// Neighbor-joining tree builder: distance matrix store, join sequencer and
// output register. Depends on njtb_pkg, njtb_ram and njtb_div.
//
//  channel | direction | handshake               | beat
//  --------+-----------+-------------------------+-----------------------------------
//  in      | in        | in_valid / in_stall     | row, col, distance, leaf_id, last
//  out     | out       | out_valid / out_stall   | one join record per beat
//  apb     | in        | psel/penable/pready     | taxa_count, outgroup_first, prev_gen
//
// Matrix entries load one per cycle while in_stall is low. A beat with last
// set starts a run, and in_stall stays high until the closing record has
// been handed to the output register. Row sums and the pair search each
// sweep the matrix RAM one entry a cycle, the floor divide takes one
// quotient bit a cycle, and deleting a row and a column walks the RAM
// read/write ports one entry a cycle. out_stall only holds the sequencer
// at its record hand-off. No clearing pass after reset.
module neighbor_joining_tree_builder_unit #(
	parameter int MAX_TAXA = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	// entry channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [4:0]         row,
	input  logic [4:0]         col,
	input  logic signed [31:0] distance,
	input  logic [9:0]         leaf_id,
	input  logic               last,
	// join record channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [10:0]        left_id,
	output logic [10:0]        right_id,
	output logic [10:0]        parent_id,
	output logic signed [31:0] left_length,
	output logic signed [31:0] right_length,
	output logic               left_prev_gen,
	output logic               right_prev_gen,
	output logic               last_join,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import njtb_pkg::*;

	localparam int IW    = $clog2(MAX_TAXA);
	localparam int CW    = $clog2(MAX_TAXA + 1);
	localparam int DEN_W = CW + 1;
	localparam int AW    = 2 * IW;
	localparam int DEPTH = 1 << AW;
	localparam int PW    = 33 + CW;

	typedef enum logic [24:0] {
		ST_IDLE  = 25'h0000001,
		ST_START = 25'h0000002,
		ST_SUM   = 25'h0000004,
		ST_SDRN  = 25'h0000008,
		ST_QROW  = 25'h0000010,
		ST_QCOL  = 25'h0000020,
		ST_QDRN  = 25'h0000040,
		ST_LRD   = 25'h0000080,
		ST_LSY   = 25'h0000100,
		ST_LNUM  = 25'h0000200,
		ST_DIVW  = 25'h0000400,
		ST_LFIX  = 25'h0000800,
		ST_LFIX2 = 25'h0001000,
		ST_EMIT  = 25'h0002000,
		ST_UA    = 25'h0004000,
		ST_UB    = 25'h0008000,
		ST_UC    = 25'h0010000,
		ST_UD    = 25'h0020000,
		ST_SHSET = 25'h0040000,
		ST_RSH   = 25'h0080000,
		ST_CSET  = 25'h0100000,
		ST_CSH   = 25'h0200000,
		ST_RELAB = 25'h0400000,
		ST_FRD   = 25'h0800000,
		ST_FRD2  = 25'h1000000
	} state_t;

	function automatic logic [AW-1:0] mk_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
		return {r, c};
	endfunction

	// ---------------- configuration registers ----------------
	logic [5:0] taxa_q;
	logic       outg_q;
	logic [5:0] pgc_q;
	logic       cfg_wr;

	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taxa_q <= 6'd2;
			outg_q <= 1'b0;
			pgc_q  <= 6'd0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_TAXA_COUNT:     taxa_q <= pwdata[5:0];
				REG_OUTGROUP_FIRST: outg_q <= pwdata[0];
				REG_PREV_GEN_COUNT: pgc_q  <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_TAXA_COUNT:     prdata = {26'd0, taxa_q};
			REG_OUTGROUP_FIRST: prdata = {31'd0, outg_q};
			REG_PREV_GEN_COUNT: prdata = {26'd0, pgc_q};
			default:            prdata = 32'd0;
		endcase
	end

	// ---------------- state ----------------
	state_t state_q;

	logic [CW-1:0] n_q, i_q, j_q;
	logic [IW-1:0] x_q, y_q;
	logic [10:0]   next_q;
	logic          found_q;
	logic          fin_q;
	logic signed [NUM_W-1:0] best_q;
	logic signed [SUM_W-1:0] acc_q, si_q, sx_q, sy_q;
	logic signed [31:0]      dxy_q, a_q, v_q;
	logic signed [NUM_W-1:0] d_q, dv_q;
	logic signed [31:0]      len_l_q, len_r_q;
	logic [10:0]   lx_q, ly_q;
	logic          fx_q, fy_q;

	// per-row stores
	logic signed [SUM_W-1:0] rsum_q [MAX_TAXA];
	logic [10:0]             lab_q  [MAX_TAXA];
	logic [MAX_TAXA-1:0]     pgf_q;

	// pipelines
	logic          sv_s1, sj0_s1, sjl_s1;
	logic [IW-1:0] si_s1;
	logic          qv_s1, qv_s2;
	logic [IW-1:0] qx_s1, qy_s1, qx_s2, qy_s2;
	logic signed [SUM_W-1:0] ss_s1, ss_s2;
	logic signed [NUM_W-1:0] p_s2;
	logic          shv_s1;
	logic [AW-1:0] shaddr_s1;

	// output register
	logic        out_valid_q;
	logic [10:0] o_left_q, o_right_q, o_par_q;
	logic signed [31:0] o_ll_q, o_rl_q;
	logic        o_lp_q, o_rp_q, o_last_q;

	// ---------------- combinational helpers ----------------
	logic          in_acc;
	logic          row_ok;
	logic [CW-1:0] nm1, nm2, n_clamp;
	logic [IW-1:0] ii, jj;
	logic [CW-1:0] i_inc, j_inc;
	logic [IW-1:0] rs_idx, lab_idx;
	logic signed [SUM_W-1:0] rs_rd;
	logic [10:0]   lab_rd;
	logic          flg_rd;
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   ram_wdata, ram_rdata;
	logic signed [31:0]   mul_a;
	logic signed [PW-1:0] prod;
	logic signed [SUM_W-1:0] acc_nx;
	logic signed [NUM_W-1:0] q_val, num, dv0, upd_t;
	logic signed [31:0]      vnew;
	logic          div_done;
	logic signed [NUM_W-1:0] div_quo;
	logic          out_free;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign row_ok   = (32'(row) < MAX_TAXA) && (32'(col) < MAX_TAXA);
	assign nm1      = n_q - 1'b1;
	assign nm2      = n_q - CW'(2);
	assign ii       = i_q[IW-1:0];
	assign jj       = j_q[IW-1:0];
	assign i_inc    = i_q + 1'b1;
	assign j_inc    = j_q + 1'b1;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		if (taxa_q < 6'd2) begin
			n_clamp = CW'(2);
		end else if (32'(taxa_q) > MAX_TAXA) begin
			n_clamp = CW'(MAX_TAXA);
		end else begin
			n_clamp = CW'(taxa_q);
		end
	end

	// row-sum and label read selects
	always_comb begin
		case (state_q)
			ST_QROW: rs_idx = ii;
			ST_QCOL: rs_idx = jj;
			ST_LRD:  rs_idx = x_q;
			ST_LSY:  rs_idx = y_q;
			default: rs_idx = ii;
		endcase
		case (state_q)
			ST_LSY:  lab_idx = y_q;
			ST_FRD:  lab_idx = '0;
			ST_FRD2: lab_idx = IW'(1);
			default: lab_idx = x_q;
		endcase
	end

	assign rs_rd  = rsum_q[rs_idx];
	assign lab_rd = lab_q[lab_idx];
	assign flg_rd = pgf_q[lab_idx];

	// matrix RAM read address
	always_comb begin
		case (state_q)
			ST_SUM:  ram_raddr = mk_addr(ii, jj);
			ST_QCOL: ram_raddr = mk_addr(ii, jj);
			ST_LRD:  ram_raddr = mk_addr(x_q, y_q);
			ST_UA:   ram_raddr = mk_addr(x_q, ii);
			ST_UB:   ram_raddr = mk_addr(y_q, ii);
			ST_RSH:  ram_raddr = mk_addr(i_inc[IW-1:0], jj);
			ST_CSH:  ram_raddr = mk_addr(ii, j_inc[IW-1:0]);
			ST_FRD:  ram_raddr = mk_addr('0, IW'(1));
			default: ram_raddr = '0;
		endcase
	end

	// shared multiplier, matrix update value
	always_comb begin
		mul_a  = (state_q == ST_LNUM) ? dxy_q : $signed(ram_rdata);
		prod   = mul_a * $signed({1'b0, nm2});
		acc_nx = (sj0_s1 ? SUM_W'(0) : acc_q) + SUM_W'($signed(ram_rdata));
		q_val  = p_s2 - NUM_W'(ss_s2);
		num    = NUM_W'(prod) + NUM_W'(sx_q) - NUM_W'(sy_q);
		dv0    = NUM_W'(dxy_q) - div_quo;
		upd_t  = NUM_W'(a_q) + NUM_W'($signed(ram_rdata)) - NUM_W'(dxy_q);
		vnew   = sat32(upd_t >>> 1);
	end

	// matrix RAM write port
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = distance;
		if (state_q == ST_IDLE) begin
			ram_we    = in_acc && row_ok;
			ram_waddr = mk_addr(IW'(row), IW'(col));
			ram_wdata = distance;
		end else if (state_q == ST_UC) begin
			ram_we    = 1'b1;
			ram_waddr = mk_addr(x_q, ii);
			ram_wdata = vnew;
		end else if (state_q == ST_UD) begin
			ram_we    = 1'b1;
			ram_waddr = mk_addr(ii, x_q);
			ram_wdata = v_q;
		end else if (shv_s1) begin
			ram_we    = 1'b1;
			ram_waddr = shaddr_s1;
			ram_wdata = ram_rdata;
		end
	end

	njtb_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_dist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	njtb_div #(.DEN_W(DEN_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_LNUM),
		.num    (num),
		.den    ({nm2, 1'b0}),
		.done   (div_done),
		.quo    (div_quo)
	);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= CW'(2);
			i_q     <= '0;
			j_q     <= '0;
			x_q     <= '0;
			y_q     <= IW'(1);
			next_q  <= FIRST_INTERNAL;
			found_q <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			// pair search result
			if (qv_s2 && (!found_q || q_val < best_q)) begin
				x_q     <= qx_s2;
				y_q     <= qy_s2;
				found_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && last) begin
						n_q     <= n_clamp;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					next_q  <= FIRST_INTERNAL;
					i_q     <= '0;
					j_q     <= '0;
					state_q <= (n_q == CW'(2)) ? ST_FRD : ST_SUM;
				end
				ST_SUM: begin
					if (j_q == nm1) begin
						j_q <= '0;
						if (i_q == nm1) begin
							state_q <= ST_SDRN;
						end else begin
							i_q <= i_inc;
						end
					end else begin
						j_q <= j_inc;
					end
				end
				ST_SDRN: begin
					i_q     <= CW'(outg_q);
					found_q <= 1'b0;
					state_q <= ST_QROW;
				end
				ST_QROW: begin
					j_q     <= i_inc;
					state_q <= ST_QCOL;
				end
				ST_QCOL: begin
					if (j_q == nm1) begin
						if (i_q == nm2) begin
							state_q <= ST_QDRN;
						end else begin
							i_q     <= i_inc;
							state_q <= ST_QROW;
						end
					end else begin
						j_q <= j_inc;
					end
				end
				ST_QDRN: begin
					if (!qv_s1 && !qv_s2) begin
						state_q <= ST_LRD;
					end
				end
				ST_LRD: begin
					fin_q   <= 1'b0;
					state_q <= ST_LSY;
				end
				ST_LSY:  state_q <= ST_LNUM;
				ST_LNUM: state_q <= ST_DIVW;
				ST_DIVW: begin
					if (div_done) begin
						state_q <= ST_LFIX;
					end
				end
				ST_LFIX:  state_q <= ST_LFIX2;
				ST_LFIX2: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_free) begin
						i_q     <= '0;
						state_q <= fin_q ? ST_IDLE : ST_UA;
					end
				end
				ST_UA: begin
					if (ii == x_q || ii == y_q) begin
						if (i_q == nm1) begin
							state_q <= ST_SHSET;
						end else begin
							i_q <= i_inc;
						end
					end else begin
						state_q <= ST_UB;
					end
				end
				ST_UB: state_q <= ST_UC;
				ST_UC: state_q <= ST_UD;
				ST_UD: begin
					if (i_q == nm1) begin
						state_q <= ST_SHSET;
					end else begin
						i_q     <= i_inc;
						state_q <= ST_UA;
					end
				end
				ST_SHSET: begin
					if (CW'(y_q) == nm1) begin
						state_q <= ST_RELAB;
					end else begin
						i_q     <= CW'(y_q);
						j_q     <= '0;
						state_q <= ST_RSH;
					end
				end
				ST_RSH: begin
					if (j_q == nm1) begin
						j_q <= '0;
						if (i_q == nm2) begin
							state_q <= ST_CSET;
						end else begin
							i_q <= i_inc;
						end
					end else begin
						j_q <= j_inc;
					end
				end
				ST_CSET: begin
					i_q     <= '0;
					j_q     <= CW'(y_q);
					state_q <= ST_CSH;
				end
				ST_CSH: begin
					if (j_q == nm2) begin
						j_q <= CW'(y_q);
						if (i_q == nm2) begin
							state_q <= ST_RELAB;
						end else begin
							i_q <= i_inc;
						end
					end else begin
						j_q <= j_inc;
					end
				end
				ST_RELAB: begin
					n_q     <= nm1;
					next_q  <= next_q + 11'd1;
					i_q     <= '0;
					j_q     <= '0;
					state_q <= (nm1 > CW'(2)) ? ST_SUM : ST_FRD;
				end
				ST_FRD: state_q <= ST_FRD2;
				ST_FRD2: begin
					fin_q   <= 1'b1;
					state_q <= ST_EMIT;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		// row-sum accumulation
		if (sv_s1) begin
			acc_q <= acc_nx;
			if (sjl_s1) begin
				rsum_q[si_s1] <= acc_nx;
			end
		end
		if (qv_s2 && (!found_q || q_val < best_q)) begin
			best_q <= q_val;
		end
		case (state_q)
			ST_QROW: si_q <= rs_rd;
			ST_LRD: begin
				sx_q <= rs_rd;
				lx_q <= lab_rd;
				fx_q <= flg_rd;
			end
			ST_LSY: begin
				dxy_q <= $signed(ram_rdata);
				sy_q  <= rs_rd;
				ly_q  <= lab_rd;
				fy_q  <= flg_rd;
			end
			// right branch negative: its excess moves to the left
			ST_LFIX: begin
				if (dv0 < 0) begin
					d_q  <= div_quo - dv0;
					dv_q <= '0;
				end else begin
					d_q  <= div_quo;
					dv_q <= dv0;
				end
			end
			// left branch negative: move excess to right
			ST_LFIX2: begin
				if (d_q < 0) begin
					len_l_q <= 32'sd0;
					len_r_q <= sat32(dv_q - d_q);
				end else begin
					len_l_q <= sat32(d_q);
					len_r_q <= sat32(dv_q);
				end
			end
			ST_UB: a_q <= $signed(ram_rdata);
			ST_UC: v_q <= vnew;
			ST_FRD: begin
				lx_q <= lab_rd;
				fx_q <= flg_rd;
			end
			ST_FRD2: begin
				ly_q    <= lab_rd;
				fy_q    <= flg_rd;
				len_l_q <= 32'sd0;
				len_r_q <= $signed(ram_rdata);
			end
			default: ;
		endcase
	end

	// pipeline payloads
	always_ff @(posedge clk) begin
		si_s1     <= ii;
		sj0_s1    <= (j_q == '0);
		sjl_s1    <= (j_q == nm1);
		qx_s1     <= ii;
		qy_s1     <= jj;
		ss_s1     <= si_q + rs_rd;
		qx_s2     <= qx_s1;
		qy_s2     <= qy_s1;
		ss_s2     <= ss_s1;
		p_s2      <= NUM_W'(prod);
		shaddr_s1 <= mk_addr(ii, jj);
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_s1  <= 1'b0;
			qv_s1  <= 1'b0;
			qv_s2  <= 1'b0;
			shv_s1 <= 1'b0;
		end else begin
			sv_s1  <= (state_q == ST_SUM);
			qv_s1  <= (state_q == ST_QCOL);
			qv_s2  <= qv_s1;
			shv_s1 <= (state_q == ST_RSH) || (state_q == ST_CSH);
		end
	end

	// leaf labels: load from entries, relabel and shift after a join
	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_TAXA; k++) begin
			if (state_q == ST_IDLE) begin
				if (in_acc && row_ok && col == 5'd0 && IW'(row) == IW'(k)) begin
					lab_q[k] <= {1'b0, leaf_id};
				end
			end else if (state_q == ST_RELAB) begin
				if (k < MAX_TAXA - 1 && IW'(k) >= y_q && CW'(k + 1) < n_q) begin
					lab_q[k] <= lab_q[(k + 1) % MAX_TAXA];
				end else if (IW'(k) == x_q) begin
					lab_q[k] <= next_q;
				end
			end
		end
	end

	// previous-generation flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pgf_q <= '0;
		end else begin
			for (int k = 0; k < MAX_TAXA; k++) begin
				if (state_q == ST_START) begin
					if (CW'(k) < n_q) begin
						pgf_q[k] <= (32'(k) < 32'(pgc_q));
					end
				end else if (state_q == ST_RELAB) begin
					if (k < MAX_TAXA - 1 && IW'(k) >= y_q && CW'(k + 1) < n_q) begin
						pgf_q[k] <= pgf_q[(k + 1) % MAX_TAXA];
					end else if (IW'(k) == x_q) begin
						pgf_q[k] <= 1'b0;
					end
				end
			end
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			o_left_q  <= lx_q;
			o_right_q <= ly_q;
			o_par_q   <= next_q;
			o_ll_q    <= len_l_q;
			o_rl_q    <= len_r_q;
			o_lp_q    <= fx_q;
			o_rp_q    <= fy_q;
			o_last_q  <= fin_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign left_id        = o_left_q;
	assign right_id       = o_right_q;
	assign parent_id      = o_par_q;
	assign left_length    = o_ll_q;
	assign right_length   = o_rl_q;
	assign left_prev_gen  = o_lp_q;
	assign right_prev_gen = o_rp_q;
	assign last_join      = o_last_q;

endmodule
